/* design/fps_pkg.sv */
// Shared types and constants for the binary indexed tree prefix-sum unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package fps_pkg;

   localparam int SIZE        = 4096;
   localparam int POS_W       = 13;
   localparam int DATA_W      = 32;
   localparam int NODE_ADDR_W = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int WALK_W      = ($clog2(SIZE) + 2 > POS_W + 1) ? $clog2(SIZE) + 2 : POS_W + 1;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] delta;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prefix_sum;
      logic                     bad_position;
   } rsp_word_type;

   typedef struct packed {
      logic                   rd_en;
      logic [NODE_ADDR_W-1:0] rd_addr;
      logic                   wr_en;
      logic [NODE_ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0]      wr_data;
   } mem_req_type;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_QUERY = 6'b001000,
      ST_CLEAR = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

/* design/fps_node_mem.sv */
// Node storage of the tree: one write port, one read port, registered read data.
// Depends on fps_pkg.
`timescale 1ns / 1ps

module fps_node_mem
   import fps_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] node_mem [SIZE];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         node_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= node_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fps_ctrl.sv */
// Sequencer of the unit: walks the tree one node per cycle for add and query,
// sweeps the memory for clear and after reset, and holds the result register.
// Depends on fps_pkg.
`timescale 1ns / 1ps

module fps_ctrl
   import fps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   output mem_req_type       mem_req,
   input  logic [DATA_W-1:0] rd_data
);

   localparam logic [WALK_W-1:0]      SIZE_WALK = WALK_W'(SIZE);
   localparam logic [NODE_ADDR_W-1:0] LAST_ADDR = NODE_ADDR_W'(SIZE - 1);

   state_type              state_ff, state_in;
   logic [WALK_W-1:0]      walk_ff, walk_in;
   logic [DATA_W-1:0]      delta_ff, delta_in;
   logic [DATA_W-1:0]      sum_ff, sum_in;
   logic                   bad_ff, bad_in;
   logic [NODE_ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [WALK_W-1:0]      req_pos;
   logic [WALK_W-1:0]      query_pos;
   logic [WALK_W-1:0]      add_next;
   logic [WALK_W-1:0]      query_next;
   logic [DATA_W-1:0]      query_acc;

   function automatic logic [NODE_ADDR_W-1:0] node_addr(input logic [WALK_W-1:0] p);
      logic [WALK_W-1:0] tmp;
      tmp = p - WALK_W'(1);
      return tmp[NODE_ADDR_W-1:0];
   endfunction

   assign req_pos    = WALK_W'(req_word.position);
   assign query_pos  = (req_pos > SIZE_WALK) ? SIZE_WALK : req_pos;
   assign add_next   = walk_ff + (walk_ff & (~walk_ff + WALK_W'(1)));
   assign query_next = walk_ff & (walk_ff - WALK_W'(1));
   assign query_acc  = sum_ff + rd_data;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      bad_in       = bad_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem_req      = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               delta_in   = req_word.delta;
               sum_in     = '0;
               bad_in     = 1'b0;
               clr_cnt_in = '0;
               case (req_word.func)
                  FUNC_ADD: begin
                     if (req_pos == '0) begin
                        bad_in   = 1'b1;
                        state_in = ST_DONE;
                     end else if (req_pos > SIZE_WALK) begin
                        state_in = ST_DONE;
                     end else begin
                        walk_in         = req_pos;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = node_addr(req_pos);
                        state_in        = ST_ADD;
                     end
                  end
                  FUNC_QUERY: begin
                     if (query_pos == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        walk_in         = query_pos;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = node_addr(query_pos);
                        state_in        = ST_QUERY;
                     end
                  end
                  FUNC_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = node_addr(walk_ff);
            mem_req.wr_data = rd_data + delta_ff;
            if (add_next <= SIZE_WALK) begin
               walk_in         = add_next;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_addr(add_next);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QUERY: begin
            sum_in = query_acc;
            if (query_next != '0) begin
               walk_in         = query_next;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_addr(query_next);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR, ST_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_cnt_ff;
            mem_req.wr_data = '0;
            clr_cnt_in      = clr_cnt_ff + NODE_ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.prefix_sum   = sum_ff;
               rsp_word_in.bad_position = bad_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      delta_ff    <= delta_in;
      sum_ff      <= sum_in;
      bad_ff      <= bad_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* design/fenwick_prefix_sum_unit.sv */
// Binary indexed tree of SIZE 32-bit counters with add, prefix query and clear.
// After reset the unit sweeps its node memory to zero and holds req_ready low
// meanwhile. An add or a query walks the tree one node per cycle through a
// single-port-read memory with registered read data, visiting at most
// log2(SIZE)+1 nodes (13 at SIZE = 4096); the word is accepted before the walk
// and its result is loaded after it. A clear writes one node per cycle. An add
// at position zero is dropped and answered with bad_position set. One result
// word per request; the result register lets the next request in while a
// result waits.
// Depends on fps_pkg, fps_ctrl and fps_node_mem.
`timescale 1ns / 1ps

module fenwick_prefix_sum_unit
   import fps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;

   fps_ctrl u_fps_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   fps_node_mem u_fps_node_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* design/fps_checker.sv */
// Port-level checks for fenwick_prefix_sum_unit, bound to the top level.
// Depends on fps_pkg.
`timescale 1ns / 1ps

module fps_checker
   import fps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   a_bad_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_position |-> rsp_word.prefix_sum == '0)
      else $error("bad position result carries a nonzero sum");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_init_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken before memory sweep finished");

endmodule

bind fenwick_prefix_sum_unit fps_checker u_fps_checker (.*);
